// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the following edge, checked through reset too
`define ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// widths and constants for the rgb to hsl converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

  localparam int RGB_W   = 8;
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int QUO_W   = 9;
  localparam int TDATA_W = 24;

  localparam int HUE_MAX = 360;
  localparam int PCT_MAX = 100;

endpackage

`default_nettype wire

// ===== hdl/rgbhsl_div.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 9,
  parameter int QUO_W = rgbhsl_pkg::QUO_W
) (
  input  wire logic             clk,
  input  wire logic [QUO_W-1:0] en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  logic [NUM_W-1:0] num_hi;

  // quotient fits in QUO_W bits, so the top numerator bits are below den
  assign num_hi = num >> QUO_W;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    if (k == 0) begin : g_first
      assign rem_in = num_hi[DEN_W-1:0];
      assign low_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      trial    = {rem_in, low_in[QUO_W-1]};
      fits     = (trial >= {1'b0, den_in});
      rem_next = fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_next;
        low_r[k] <= {low_in[QUO_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[QUO_W-2:0], fits};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsl_convert.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert
// 8-bit rgb pixel to rounded hue (degrees), saturation and lightness (percent)
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata, lsb first)
// s_axis   in   red[7:0] green[15:8] blue[23:16]
// m_axis   out  hue[8:0] saturation[15:9] lightness[22:16], bit 23 zero
//
// one pixel per clock sustained while m_tready is high: min/max stage, numerator
// stage, then nine restoring divider stages (one quotient bit each) for hue
// and saturation; lightness is a reciprocal multiply carried alongside
// rst clears all stage valid bits; payload registers are not reset
// each stage holds its beat while the next one is full and stalled; s_tready
// falls only when every stage is full and m_tready is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsl_convert (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [rgbhsl_pkg::TDATA_W-1:0]  s_tdata,  // red, green, blue
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [rgbhsl_pkg::TDATA_W-1:0]  m_tdata   // hue, saturation, lightness
);

  import rgbhsl_pkg::*;

  localparam int NS = 2 + QUO_W;

  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_t;

  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[NS-1];

  // stage 1: max, min, sum, spread, hue difference term
  logic [RGB_W-1:0] red, green, blue;
  logic [RGB_W-1:0] hi, lo;
  max_sel_t         sel_next;
  logic signed [RGB_W:0] t_next;

  assign red   = s_tdata[RGB_W-1:0];
  assign green = s_tdata[2*RGB_W-1:RGB_W];
  assign blue  = s_tdata[3*RGB_W-1:2*RGB_W];

  always_comb begin
    if (red >= green && red >= blue) begin
      sel_next = MAX_RED;
      hi       = red;
      t_next   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sel_next = MAX_GREEN;
      hi       = green;
      t_next   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sel_next = MAX_BLUE;
      hi       = blue;
      t_next   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
  end

  logic [RGB_W:0]        sum;
  logic [RGB_W-1:0]      diff;
  max_sel_t              sel;
  logic signed [RGB_W:0] t;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sum  <= {1'b0, hi} + {1'b0, lo};
      diff <= hi - lo;
      sel  <= sel_next;
      t    <= t_next;
    end
  end

  // stage 2: rounding numerators and doubled denominators
  localparam int LNUM_W = 14;
  localparam int SNUM_W = 16;
  localparam int SDEN_W = 9;
  localparam int HNUM_W = 18;
  localparam int HDEN_W = 9;

  // x / 102 as (x * 10281) >> 20, exact for x up to 10251
  localparam int LREC    = 10281;
  localparam int LSHIFT  = 20;
  localparam int LPROD_W = 28;

  logic [RGB_W-1:0]        sden8;
  logic [HNUM_W-1:0]       base2;
  logic signed [HNUM_W+1:0] hacc;
  logic [LNUM_W-1:0]       lnum_next;
  logic [SNUM_W-1:0]       snum_next;
  logic [SDEN_W-1:0]       sden_next;
  logic [HNUM_W-1:0]       hnum_next;
  logic [HDEN_W-1:0]       hden_next;

  always_comb begin
    lnum_next = LNUM_W'(sum) * LNUM_W'(20) + LNUM_W'(51);
    sden8     = (sum > 9'd255) ? RGB_W'(9'd510 - sum) : sum[RGB_W-1:0];
    case (sel)
      MAX_RED:   base2 = (t < 0) ? HNUM_W'(diff) * HNUM_W'(720) : '0;
      MAX_GREEN: base2 = HNUM_W'(diff) * HNUM_W'(240);
      default:   base2 = HNUM_W'(diff) * HNUM_W'(480);
    endcase
    hacc = (HNUM_W+2)'(t) * (HNUM_W+2)'(120)
         + $signed((HNUM_W+2)'(base2))
         + $signed((HNUM_W+2)'(diff));
    if (diff == '0) begin
      snum_next = '0;
      sden_next = SDEN_W'(1);
      hnum_next = '0;
      hden_next = HDEN_W'(1);
    end else begin
      snum_next = SNUM_W'(diff) * SNUM_W'(200) + SNUM_W'(sden8);
      sden_next = {sden8, 1'b0};
      hnum_next = hacc[HNUM_W-1:0];
      hden_next = {diff, 1'b0};
    end
  end

  logic [LNUM_W-1:0] lnum;
  logic [SNUM_W-1:0] snum;
  logic [SDEN_W-1:0] sden;
  logic [HNUM_W-1:0] hnum;
  logic [HDEN_W-1:0] hden;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      lnum <= lnum_next;
      snum <= snum_next;
      sden <= sden_next;
      hnum <= hnum_next;
      hden <= hden_next;
    end
  end

  // stages 3 to 11: two dividers and the lightness line in lockstep
  logic [QUO_W-1:0]   hue_q, sat_q;
  logic [LPROD_W-1:0] lprod;
  logic [PCT_W-1:0]   light_next;
  logic [PCT_W-1:0]   light_pipe [QUO_W];

  assign lprod      = LPROD_W'(lnum) * LPROD_W'(LREC);
  assign light_next = PCT_W'(lprod >> LSHIFT);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      light_pipe[0] <= light_next;
    end
    for (int i = 1; i < QUO_W; i++) begin
      if (rdy[i+2]) begin
        light_pipe[i] <= light_pipe[i-1];
      end
    end
  end

  rgbhsl_div #(.NUM_W(HNUM_W), .DEN_W(HDEN_W), .QUO_W(QUO_W)) u_hue_div (
    .clk (clk),
    .en  (rdy[NS-1:2]),
    .num (hnum),
    .den (hden),
    .quo (hue_q)
  );

  rgbhsl_div #(.NUM_W(SNUM_W), .DEN_W(SDEN_W), .QUO_W(QUO_W)) u_sat_div (
    .clk (clk),
    .en  (rdy[NS-1:2]),
    .num (snum),
    .den (sden),
    .quo (sat_q)
  );

  assign m_tdata = {1'b0, light_pipe[QUO_W-1], sat_q[PCT_W-1:0], hue_q[HUE_W-1:0]};

  `ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid, "output valid right after reset")
  `ASSERT_ALWAYS(a_hue_range, clk, rst,
    !m_tvalid || m_tdata[HUE_W-1:0] <= HUE_W'(HUE_MAX), "hue above 360")
  `ASSERT_ALWAYS(a_pct_range, clk, rst,
    !m_tvalid || (m_tdata[15:9] <= PCT_W'(PCT_MAX) && m_tdata[22:16] <= PCT_W'(PCT_MAX)),
    "percent above 100")
  `ASSERT_ALWAYS(a_full_stall, clk, rst,
    !((&v) && !m_tready) || !s_tready, "input ready while pipeline full and stalled")

endmodule

`default_nettype wire
